@@ rtl/assert_macros.svh @@
// Assertion macros shared by sdc_angle_reduce and sky_direction_cosines_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define SDC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("sdc assertion failed");
`define SDC_ASSERT_IMP(lbl, clk, rst_n, cond, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("sdc assertion failed");
`else
`define SDC_ASSERT(lbl, clk, rst_n, prop)
`define SDC_ASSERT_IMP(lbl, clk, rst_n, cond, prop)
`endif
`endif

@@ rtl/sdc_pkg.sv @@
`default_nettype none
package sdc_pkg;

	localparam int AF    = 28;
	localparam int VF    = 30;
	localparam int STEPS = 30;
	localparam int AW    = 33;
	localparam int VW    = 34;
	localparam int MW    = 36;
	localparam int OW    = 32;
	localparam int LANES = 2;

	typedef logic signed [AW-1:0]   angle_t;
	typedef logic signed [VW-1:0]   value_t;
	typedef logic signed [MW-1:0]   mul_t;
	typedef logic signed [2*MW-1:0] prod_t;
	typedef logic signed [OW-1:0]   out_t;
	typedef logic [1:0]             cfg_idx_t;

	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

	localparam cfg_idx_t REG_CENTRE_RA   = 2'd0;
	localparam cfg_idx_t REG_CENTRE_SDEC = 2'd1;
	localparam cfg_idx_t REG_CENTRE_CDEC = 2'd2;

	localparam logic [63:0] PI_Q60   = 64'h3243F6A8885A308D;
	localparam logic [63:0] GAIN_Q62 = 64'd2800459870029452964;

	function automatic logic [63:0] round_shift(input logic [63:0] v, input int s);
		return (v + (64'd1 << (s - 1))) >> s;
	endfunction

	localparam angle_t PI_A      = angle_t'(round_shift(PI_Q60, 60 - AF));
	localparam angle_t HALF_PI_A = angle_t'(round_shift(PI_Q60, 61 - AF));
	localparam angle_t TWO_PI_A  = angle_t'(round_shift(PI_Q60, 59 - AF));
	localparam value_t CORDIC_K  = value_t'(round_shift(GAIN_Q62, 62 - VF));
	localparam out_t   ONE_OUT   = out_t'(64'd1 << VF);

	function automatic logic [63:0] atan_q60(input int i);
		logic signed [63:0] sum;
		logic [63:0] t;
		int e;
		sum = '0;
		if (i == 0)
			return PI_Q60 >> 2;
		for (int k = 0; (2 * k + 1) * i <= 60; k++) begin
			e = 60 - (2 * k + 1) * i;
			t = (64'd1 << e) / 64'(2 * k + 1);
			sum = k[0] ? sum - $signed(t) : sum + $signed(t);
		end
		return sum;
	endfunction

	typedef angle_t atan_tab_t [STEPS];

	function automatic atan_tab_t build_atan();
		atan_tab_t tab;
		for (int i = 0; i < STEPS; i++)
			tab[i] = angle_t'(round_shift(atan_q60(i), 60 - AF));
		return tab;
	endfunction

	localparam atan_tab_t ATAN_TAB = build_atan();

	// Product rounded half away from zero to the value format.
	function automatic mul_t qmul(input mul_t a, input mul_t b);
		prod_t p;
		logic [2*MW-1:0] mag;
		logic [2*MW-1:0] r;
		p = a * b;
		mag = p[2*MW-1] ? (2*MW)'(-p) : (2*MW)'(p);
		r = (mag + ((2*MW)'(1) << (VF - 1))) >> VF;
		return p[2*MW-1] ? -mul_t'(r) : mul_t'(r);
	endfunction

	function automatic out_t sat_out(input logic signed [MW:0] v);
		if (v > (MW+1)'(ONE_OUT))
			return ONE_OUT;
		if (v < -(MW+1)'(ONE_OUT))
			return -ONE_OUT;
		return out_t'(v);
	endfunction

endpackage
`default_nettype wire

@@ rtl/sdc_angle_reduce.sv @@
`default_nettype none
`include "assert_macros.svh"
module sdc_angle_reduce (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  en,
	input  wire sdc_pkg::ctl_t         ctl_i,
	input  wire logic [30:0]           ra,
	input  wire logic signed [29:0]    dec,
	input  wire logic [30:0]           ra0,
	output sdc_pkg::ctl_t              ctl_o,
	output sdc_pkg::angle_t            dec_o,
	output sdc_pkg::angle_t            dra_o,
	output logic                       dec_flip_o,
	output logic                       dra_flip_o
);

	sdc_pkg::ctl_t  ctl_s1, ctl_s2, ctl_s3;
	sdc_pkg::angle_t dec_s1, dra_s1, dec_s2, dra_s2, dec_s3, dra_s3;
	logic dec_flip_s3, dra_flip_s3;

	function automatic sdc_pkg::angle_t wrap(input sdc_pkg::angle_t a);
		sdc_pkg::angle_t r;
		if (a >= sdc_pkg::TWO_PI_A)
			r = a - sdc_pkg::TWO_PI_A;
		else if (a <= -sdc_pkg::TWO_PI_A)
			r = a + sdc_pkg::TWO_PI_A;
		else
			r = a;
		if (r > sdc_pkg::PI_A)
			r = r - sdc_pkg::TWO_PI_A;
		else if (r <= -sdc_pkg::PI_A)
			r = r + sdc_pkg::TWO_PI_A;
		return r;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dec_s1 <= sdc_pkg::angle_t'(dec);
			dra_s1 <= sdc_pkg::angle_t'(ra) - sdc_pkg::angle_t'(ra0);
			dec_s2 <= wrap(dec_s1);
			dra_s2 <= wrap(dra_s1);
			if (dec_s2 > sdc_pkg::HALF_PI_A) begin
				dec_s3 <= dec_s2 - sdc_pkg::PI_A;
				dec_flip_s3 <= 1'b1;
			end else if (dec_s2 < -sdc_pkg::HALF_PI_A) begin
				dec_s3 <= dec_s2 + sdc_pkg::PI_A;
				dec_flip_s3 <= 1'b1;
			end else begin
				dec_s3 <= dec_s2;
				dec_flip_s3 <= 1'b0;
			end
			if (dra_s2 > sdc_pkg::HALF_PI_A) begin
				dra_s3 <= dra_s2 - sdc_pkg::PI_A;
				dra_flip_s3 <= 1'b1;
			end else if (dra_s2 < -sdc_pkg::HALF_PI_A) begin
				dra_s3 <= dra_s2 + sdc_pkg::PI_A;
				dra_flip_s3 <= 1'b1;
			end else begin
				dra_s3 <= dra_s2;
				dra_flip_s3 <= 1'b0;
			end
		end
	end

	assign ctl_o      = ctl_s3;
	assign dec_o      = dec_s3;
	assign dra_o      = dra_s3;
	assign dec_flip_o = dec_flip_s3;
	assign dra_flip_o = dra_flip_s3;

	`SDC_ASSERT_IMP(a_dra_folded, clk, arst_n, ctl_s3.valid,
		dra_s3 <= sdc_pkg::HALF_PI_A && dra_s3 >= -sdc_pkg::HALF_PI_A)
	`SDC_ASSERT_IMP(a_dec_folded, clk, arst_n, ctl_s3.valid,
		dec_s3 <= sdc_pkg::HALF_PI_A && dec_s3 >= -sdc_pkg::HALF_PI_A)
	`SDC_ASSERT_IMP(a_wrap_range, clk, arst_n, ctl_s2.valid,
		dra_s2 <= sdc_pkg::PI_A && dra_s2 > -sdc_pkg::PI_A)

endmodule
`default_nettype wire

@@ rtl/sdc_cordic.sv @@
`default_nettype none
module sdc_cordic (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire sdc_pkg::ctl_t     ctl_i,
	input  wire sdc_pkg::angle_t   ang_i  [sdc_pkg::LANES],
	input  wire logic              flip_i [sdc_pkg::LANES],
	output sdc_pkg::ctl_t          ctl_o,
	output sdc_pkg::value_t        sin_o  [sdc_pkg::LANES],
	output sdc_pkg::value_t        cos_o  [sdc_pkg::LANES]
);

	localparam int N = sdc_pkg::STEPS;
	localparam int L = sdc_pkg::LANES;

	sdc_pkg::ctl_t   ctl_s  [1:N+1];
	sdc_pkg::value_t x_s    [1:N+1][L];
	sdc_pkg::value_t y_s    [1:N+1][L];
	sdc_pkg::angle_t z_s    [1:N][L];
	logic            flip_s [1:N][L];

	for (genvar gi = 0; gi < N; gi++) begin : g_step
		sdc_pkg::ctl_t   ctl_c;
		sdc_pkg::value_t xc [L];
		sdc_pkg::value_t yc [L];
		sdc_pkg::angle_t zc [L];
		logic            fc [L];

		if (gi == 0) begin : g_first
			always_comb begin
				ctl_c = ctl_i;
				for (int l = 0; l < L; l++) begin
					xc[l] = sdc_pkg::CORDIC_K;
					yc[l] = '0;
					zc[l] = ang_i[l];
					fc[l] = flip_i[l];
				end
			end
		end else begin : g_rest
			always_comb begin
				ctl_c = ctl_s[gi];
				for (int l = 0; l < L; l++) begin
					xc[l] = x_s[gi][l];
					yc[l] = y_s[gi][l];
					zc[l] = z_s[gi][l];
					fc[l] = flip_s[gi][l];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				ctl_s[gi+1] <= '0;
			else if (en)
				ctl_s[gi+1] <= ctl_c;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				for (int l = 0; l < L; l++) begin
					flip_s[gi+1][l] <= fc[l];
					if (zc[l] >= 0) begin
						x_s[gi+1][l] <= xc[l] - (yc[l] >>> gi);
						y_s[gi+1][l] <= yc[l] + (xc[l] >>> gi);
						z_s[gi+1][l] <= zc[l] - sdc_pkg::ATAN_TAB[gi];
					end else begin
						x_s[gi+1][l] <= xc[l] + (yc[l] >>> gi);
						y_s[gi+1][l] <= yc[l] - (xc[l] >>> gi);
						z_s[gi+1][l] <= zc[l] + sdc_pkg::ATAN_TAB[gi];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s[N+1] <= '0;
		else if (en)
			ctl_s[N+1] <= ctl_s[N];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < L; l++) begin
				x_s[N+1][l] <= flip_s[N][l] ? -x_s[N][l] : x_s[N][l];
				y_s[N+1][l] <= flip_s[N][l] ? -y_s[N][l] : y_s[N][l];
			end
		end
	end

	assign ctl_o = ctl_s[N+1];
	assign sin_o = y_s[N+1];
	assign cos_o = x_s[N+1];

endmodule
`default_nettype wire

@@ rtl/sdc_combine.sv @@
`default_nettype none
module sdc_combine (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire sdc_pkg::ctl_t       ctl_i,
	input  wire sdc_pkg::value_t     sdec,
	input  wire sdc_pkg::value_t     cdec,
	input  wire sdc_pkg::value_t     sdra,
	input  wire sdc_pkg::value_t     cdra,
	input  wire logic signed [31:0]  sdec0,
	input  wire logic signed [31:0]  cdec0,
	output sdc_pkg::ctl_t            ctl_o,
	output sdc_pkg::out_t            l_o,
	output sdc_pkg::out_t            m_o,
	output sdc_pkg::out_t            n_o
);

	sdc_pkg::ctl_t ctl_s1, ctl_s2, ctl_s3;
	sdc_pkg::mul_t cc_s1, l_s1, ms_s1, ns_s1;
	sdc_pkg::mul_t l_s2, ms_s2, ns_s2, mc_s2, nc_s2;
	sdc_pkg::out_t l_s3, m_s3, n_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_i;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cc_s1 <= sdc_pkg::qmul(sdc_pkg::mul_t'(cdec), sdc_pkg::mul_t'(cdra));
			l_s1  <= sdc_pkg::qmul(sdc_pkg::mul_t'(cdec), sdc_pkg::mul_t'(sdra));
			ms_s1 <= sdc_pkg::qmul(sdc_pkg::mul_t'(sdec), sdc_pkg::mul_t'(cdec0));
			ns_s1 <= sdc_pkg::qmul(sdc_pkg::mul_t'(sdec), sdc_pkg::mul_t'(sdec0));
			l_s2  <= l_s1;
			ms_s2 <= ms_s1;
			ns_s2 <= ns_s1;
			mc_s2 <= sdc_pkg::qmul(cc_s1, sdc_pkg::mul_t'(sdec0));
			nc_s2 <= sdc_pkg::qmul(cc_s1, sdc_pkg::mul_t'(cdec0));
			l_s3  <= sdc_pkg::sat_out((sdc_pkg::MW+1)'(l_s2));
			m_s3  <= sdc_pkg::sat_out((sdc_pkg::MW+1)'(ms_s2) - (sdc_pkg::MW+1)'(mc_s2));
			n_s3  <= sdc_pkg::sat_out((sdc_pkg::MW+1)'(ns_s2) + (sdc_pkg::MW+1)'(nc_s2));
		end
	end

	assign ctl_o = ctl_s3;
	assign l_o   = l_s3;
	assign m_o   = m_s3;
	assign n_o   = n_s3;

endmodule
`default_nettype wire

@@ rtl/sky_direction_cosines_core.sv @@
// An accepted request passes through angle reduction, the CORDIC and the combiner to the outputs.
// Throughput: one request per cycle; the 30-step CORDIC and the multiplier
// stages are fully pipelined, and a stall on the output holds every stage.
// Reset clears all valid bits and loads the phase center registers with
// right ascension 0, sin(dec0) = 0 and cos(dec0) = 1.0.
`default_nettype none
`include "assert_macros.svh"
module sky_direction_cosines_core (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_we,
	input  wire logic [1:0]          cfg_index,
	input  wire logic [31:0]         cfg_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [30:0]         right_ascension,
	input  wire logic signed [29:0]  declination,
	input  wire logic                last_in,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic signed [31:0]       dir_l,
	output logic signed [31:0]       dir_m,
	output logic signed [31:0]       dir_n,
	output logic                     last_out
);

	logic [30:0]        ra0_q;
	logic signed [31:0] sdec0_q;
	logic signed [31:0] cdec0_q;

	logic en;
	sdc_pkg::ctl_t   in_ctl, red_ctl, cor_ctl, out_ctl;
	sdc_pkg::angle_t red_dec, red_dra;
	logic            red_dec_flip, red_dra_flip;
	sdc_pkg::angle_t cor_ang  [sdc_pkg::LANES];
	logic            cor_flip [sdc_pkg::LANES];
	sdc_pkg::value_t cor_sin  [sdc_pkg::LANES];
	sdc_pkg::value_t cor_cos  [sdc_pkg::LANES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ra0_q   <= '0;
			sdec0_q <= '0;
			cdec0_q <= 32'(sdc_pkg::ONE_OUT);
		end else if (cfg_we) begin
			unique case (cfg_index)
				sdc_pkg::REG_CENTRE_RA:   ra0_q   <= cfg_data[30:0];
				sdc_pkg::REG_CENTRE_SDEC: sdec0_q <= cfg_data;
				sdc_pkg::REG_CENTRE_CDEC: cdec0_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign in_ctl   = '{valid: in_valid, last: last_in};

	sdc_angle_reduce u_reduce (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.ctl_i      (in_ctl),
		.ra         (right_ascension),
		.dec        (declination),
		.ra0        (ra0_q),
		.ctl_o      (red_ctl),
		.dec_o      (red_dec),
		.dra_o      (red_dra),
		.dec_flip_o (red_dec_flip),
		.dra_flip_o (red_dra_flip)
	);

	assign cor_ang[0]  = red_dec;
	assign cor_ang[1]  = red_dra;
	assign cor_flip[0] = red_dec_flip;
	assign cor_flip[1] = red_dra_flip;

	sdc_cordic u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (red_ctl),
		.ang_i  (cor_ang),
		.flip_i (cor_flip),
		.ctl_o  (cor_ctl),
		.sin_o  (cor_sin),
		.cos_o  (cor_cos)
	);

	sdc_combine u_combine (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.ctl_i  (cor_ctl),
		.sdec   (cor_sin[0]),
		.cdec   (cor_cos[0]),
		.sdra   (cor_sin[1]),
		.cdra   (cor_cos[1]),
		.sdec0  (sdec0_q),
		.cdec0  (cdec0_q),
		.ctl_o  (out_ctl),
		.l_o    (dir_l),
		.m_o    (dir_m),
		.n_o    (dir_n)
	);

	assign out_valid = out_ctl.valid;
	assign last_out  = out_ctl.last;

	`SDC_ASSERT_IMP(a_l_range, clk, arst_n, out_valid,
		dir_l <= sdc_pkg::ONE_OUT && dir_l >= -sdc_pkg::ONE_OUT)
	`SDC_ASSERT_IMP(a_m_range, clk, arst_n, out_valid,
		dir_m <= sdc_pkg::ONE_OUT && dir_m >= -sdc_pkg::ONE_OUT)
	`SDC_ASSERT_IMP(a_n_range, clk, arst_n, out_valid,
		dir_n <= sdc_pkg::ONE_OUT && dir_n >= -sdc_pkg::ONE_OUT)

endmodule
`default_nettype wire

@@ test/tb.sv @@
`default_nettype none
module tb;

	localparam longint ONE = 64'sd1 << 30;
	localparam int LIMIT = 400000;

	class lmn_scoreboard;
		longint centre_ra;
		longint centre_sdec;
		longint centre_cdec;
		longint atan_q28[30];
		longint pi_a, half_a, two_a, gain;
		logic signed [31:0] exp_l[$], exp_m[$], exp_n[$];
		logic exp_last[$];
		int mismatches;
		int results;

		function new();
			longint unsigned pi60;
			longint sum;
			longint t;
			pi60 = 64'h3243F6A8885A308D;
			pi_a = rnd_shift(pi60, 32);
			half_a = rnd_shift(pi60, 33);
			two_a = rnd_shift(pi60, 31);
			gain = rnd_shift(64'd2800459870029452964, 32);
			atan_q28[0] = rnd_shift(pi60 >> 2, 32);
			for (int i = 1; i < 30; i++) begin
				sum = 0;
				for (int k = 0; (2 * k + 1) * i <= 60; k++) begin
					t = longint'((64'd1 << (60 - (2 * k + 1) * i)) / (2 * k + 1));
					sum = k[0] ? sum - t : sum + t;
				end
				atan_q28[i] = rnd_shift(sum, 32);
			end
			set_centre(0, 0, ONE);
		endfunction

		function longint rnd_shift(longint unsigned v, int s);
			return longint'((v + (64'd1 << (s - 1))) >> s);
		endfunction

		function void set_centre(longint ra0, longint sdec0, longint cdec0);
			centre_ra = ra0;
			centre_sdec = sdec0;
			centre_cdec = cdec0;
		endfunction

		function void sin_cos(longint a, output longint s, output longint c);
			longint r, x, y, z, dx, dy;
			bit flip;
			flip = 0;
			r = a % two_a;
			if (r > pi_a)
				r -= two_a;
			else if (r <= -pi_a)
				r += two_a;
			if (r > half_a) begin
				r -= pi_a;
				flip = 1;
			end else if (r < -half_a) begin
				r += pi_a;
				flip = 1;
			end
			x = gain;
			y = 0;
			z = r;
			for (int i = 0; i < 30; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx;
					y += dy;
					z -= atan_q28[i];
				end else begin
					x += dx;
					y -= dy;
					z += atan_q28[i];
				end
			end
			s = flip ? -y : y;
			c = flip ? -x : x;
		endfunction

		function longint fx_mul(longint a, longint b);
			bit neg;
			logic [127:0] p;
			logic [127:0] r;
			neg = (a < 0) != (b < 0);
			p = 128'(a < 0 ? -a : a) * 128'(b < 0 ? -b : b);
			r = (p + (128'd1 << 29)) >> 30;
			if (r > (128'd1 << 61))
				r = 128'd1 << 61;
			return neg ? -longint'(r) : longint'(r);
		endfunction

		function logic signed [31:0] clamp(longint v);
			if (v > ONE)
				v = ONE;
			if (v < -ONE)
				v = -ONE;
			return v[31:0];
		endfunction

		function void note(logic [30:0] ra, logic signed [29:0] dec, logic last);
			longint sd, cd, sr, cr, cc;
			sin_cos(longint'(dec), sd, cd);
			sin_cos(longint'({33'd0, ra}) - centre_ra, sr, cr);
			cc = fx_mul(cd, cr);
			exp_l.push_back(clamp(fx_mul(cd, sr)));
			exp_m.push_back(clamp(fx_mul(sd, centre_cdec) - fx_mul(cc, centre_sdec)));
			exp_n.push_back(clamp(fx_mul(sd, centre_sdec) + fx_mul(cc, centre_cdec)));
			exp_last.push_back(last);
		endfunction

		function void check(logic signed [31:0] l, logic signed [31:0] m,
				logic signed [31:0] n, logic last);
			logic signed [31:0] el, em, en;
			logic elast;
			results++;
			if (exp_l.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result l=%0d m=%0d n=%0d", l, m, n);
				return;
			end
			el = exp_l.pop_front();
			em = exp_m.pop_front();
			en = exp_n.pop_front();
			elast = exp_last.pop_front();
			if (l !== el || m !== em || n !== en || last !== elast) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"result %0d: expected l=%0d m=%0d n=%0d last=%0b, ",
						"got l=%0d m=%0d n=%0d last=%0b"},
						results, el, em, en, elast, l, m, n, last);
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [31:0] cfg_data;
	logic in_valid;
	logic in_stall;
	logic [30:0] right_ascension;
	logic signed [29:0] declination;
	logic last_in;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] dir_l, dir_m, dir_n;
	logic last_out;

	lmn_scoreboard sb;
	bit gaps_on;
	int cycles;
	int requests;

	sky_direction_cosines_core uut (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout with %0d results outstanding", sb.exp_l.size());
			$display("sky_direction_cosines_core: mismatch");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note(right_ascension, declination, last_in);
				requests++;
			end
			if (out_valid && !out_stall)
				sb.check(dir_l, dir_m, dir_n, last_out);
		end

	always @(negedge clk)
		out_stall <= gaps_on && ($urandom_range(99) < 27);

	task automatic send(logic [30:0] ra, logic signed [29:0] dec, logic last);
		while (gaps_on && $urandom_range(99) < 27) begin
			in_valid <= 0;
			@(negedge clk);
		end
		in_valid <= 1;
		right_ascension <= ra;
		declination <= dec;
		last_in <= last;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 0;
		@(negedge clk);
		while (sb.exp_l.size() != 0)
			@(negedge clk);
		repeat (45) @(negedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_centre(logic [30:0] ra0, logic signed [31:0] sdec0,
			logic signed [31:0] cdec0);
		drain();
		write_reg(sdc_pkg::REG_CENTRE_RA, {1'b0, ra0});
		write_reg(sdc_pkg::REG_CENTRE_SDEC, sdec0);
		write_reg(sdc_pkg::REG_CENTRE_CDEC, cdec0);
		sb.set_centre(longint'({33'd0, ra0}), longint'(sdec0), longint'(cdec0));
	endtask

	task automatic random_items(int count);
		logic [30:0] ra;
		logic signed [29:0] dec;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(9) == 0) begin
				ra = 31'($urandom);
				dec = 30'($urandom);
			end else begin
				ra = 31'($urandom_range(1686629713));
				dec = 30'($signed($urandom_range(843314856)) - 32'sd421657428);
			end
			send(ra, dec, 1'($urandom_range(1)));
		end
	endtask

	initial begin
		logic signed [31:0] s0, c0;
		sb = new();
		arst_n = 0;
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		in_valid = 0;
		right_ascension = 0;
		declination = 0;
		last_in = 0;
		out_stall = 0;
		gaps_on = 1;
		cycles = 0;
		requests = 0;
		repeat (12) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		send(0, 0, 0);
		send(31'd1686629713, 30'sd421657428, 1);
		send(0, -30'sd421657428, 0);
		send(31'd421657428, 0, 1);
		send(31'd843314857, 30'sd210828714, 0);
		send(31'h7FFFFFFF, 30'sd536870911, 1);
		send(31'h40000000, -30'sd536870912, 0);
		send(31'd1264972285, -30'sd210828714, 1);
		send(31'd1, 30'sd1, 0);
		send(31'd1686629712, -30'sd1, 1);
		random_items(80);

		set_centre(0, 32'sd1073741824, 0);
		send(0, 30'sd421657428, 1);
		send(31'd1686629713, 0, 0);
		random_items(80);

		set_centre(31'd1686629713, -32'sd1073741824, -32'sd1073741824);
		send(31'd1686629713, 30'sd421657428, 0);
		send(0, -30'sd421657428, 1);
		random_items(80);

		gaps_on = 0;
		set_centre(31'd843314857, 32'sd759250125, 32'sd759250125);
		random_items(120);
		gaps_on = 1;

		for (int p = 0; p < 3; p++) begin
			s0 = $signed($urandom_range(32'd2147483648)) - 32'sd1073741824;
			c0 = $signed($urandom_range(32'd2147483648)) - 32'sd1073741824;
			set_centre(31'($urandom_range(1686629713)), s0, c0);
			random_items(80);
		end

		drain();
		$display("%0d components sent under seven phase centers, %0d results checked, %0d wrong",
			requests, sb.results, sb.mismatches);
		if (sb.mismatches == 0)
			$display("sky_direction_cosines_core: match");
		else
			$display("sky_direction_cosines_core: mismatch");
		$finish;
	end

endmodule
`default_nettype wire

@@ sky_direction_cosines_core.f @@
+incdir+rtl
rtl/sdc_pkg.sv
rtl/sdc_angle_reduce.sv
rtl/sdc_cordic.sv
rtl/sdc_combine.sv
rtl/sky_direction_cosines_core.sv
test/tb.sv
